// File: design/sbmr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbmr_pkg: shared definitions for the rank-ordered spectral bin morph
// Sizes, derived widths, the sorting-chain entry type and a small helper.
// ----------------------------------------------------------------------------
package sbmr_pkg;

    localparam int HALF_SIZE   = 512;
    localparam int SAMPLE_BITS = 24;
    localparam int BINS        = HALF_SIZE + 1;
    localparam int BIN_W       = 10;
    localparam int MAG_W       = SAMPLE_BITS;
    localparam int SQ_W        = 2 * SAMPLE_BITS;
    localparam int SQRT_STEPS  = SAMPLE_BITS;
    localparam int STEP_W      = $clog2(SQRT_STEPS);

    typedef struct packed {
        logic              vld;
        logic [MAG_W-1:0]  diff;
        logic [BIN_W-1:0]  bin;
    } t_entry;

    function automatic logic [SAMPLE_BITS-1:0] abs_val(input logic [SAMPLE_BITS-1:0] x);
        abs_val = x[SAMPLE_BITS-1] ? (~x + 1'b1) : x;
    endfunction

endpackage
`default_nettype wire

// File: design/sbmr_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbmr_isqrt: iterative integer square root
// One result bit per cycle; the root is rounded down.
// ----------------------------------------------------------------------------
module sbmr_isqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [sbmr_pkg::SQ_W-1:0]   i_n,
    output logic                             o_done,
    output logic [sbmr_pkg::MAG_W-1:0]       o_root
);
    logic [sbmr_pkg::SQ_W-1:0]   r_n;
    logic [sbmr_pkg::SQ_W-1:0]   r_root;
    logic [sbmr_pkg::SQ_W-1:0]   r_bit;
    logic [sbmr_pkg::STEP_W-1:0] r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [sbmr_pkg::SQ_W-1:0]   w_trial;

    assign w_trial = r_root + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_start &&
                      (r_cnt == sbmr_pkg::STEP_W'(sbmr_pkg::SQRT_STEPS - 1));
            if (i_start) begin
                r_n    <= i_n;
                r_root <= '0;
                r_bit  <= {2'b01, {(sbmr_pkg::SQ_W-2){1'b0}}};
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_n >= w_trial) begin
                    r_n    <= r_n - w_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == sbmr_pkg::STEP_W'(sbmr_pkg::SQRT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root[sbmr_pkg::MAG_W-1:0];
endmodule
`default_nettype wire

// File: design/sbmr_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbmr_cell: one cell of the systolic insertion sorter
// Keeps the smaller of its entry and the arriving one, passes the other on; a shift loads the next cell's entry.
// ----------------------------------------------------------------------------
module sbmr_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_shift,
    input  wire sbmr_pkg::t_entry i_in,
    input  wire sbmr_pkg::t_entry i_next,
    output sbmr_pkg::t_entry      o_pass,
    output sbmr_pkg::t_entry      o_held
);
    sbmr_pkg::t_entry r_held;
    sbmr_pkg::t_entry r_pass;
    logic             w_in_first;

    // Ordering key is difference then bin, so equal differences keep bin order.
    assign w_in_first = {i_in.diff, i_in.bin} < {r_held.diff, r_held.bin};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held.vld <= 1'b0;
            r_pass.vld <= 1'b0;
        end else if (i_shift) begin
            r_held     <= i_next;
            r_pass.vld <= 1'b0;
        end else if (i_in.vld && r_held.vld) begin
            if (w_in_first) begin
                r_held <= i_in;
                r_pass <= r_held;
            end else begin
                r_pass <= i_in;
            end
        end else begin
            if (i_in.vld) begin
                r_held <= i_in;
            end
            r_pass.vld <= 1'b0;
        end
    end

    assign o_pass = r_pass;
    assign o_held = r_held;
endmodule
`default_nettype wire

// File: design/spectral_bin_morph_by_rank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spectral_bin_morph_by_rank: rank-ordered spectral bin morph of two sources
// Each bin goes through square, sum, 24-step root and output states; its
// result is registered once the output register is free. A new bin is taken
// only when the last is through; the Nyquist bin is followed by the sorter
// drain and rank sweep. Reset is synchronous and clears control state only;
// the first frame out is zero, and no clearing pass is made over the memories.
// ----------------------------------------------------------------------------
// Each input transfer writes its bin into the bank being filled and reads
// the same bin of the previous frame's bank, together with its take-two
// flag. The magnitudes of both sources are found by squaring, summing and
// two iterative square-root units; their difference is pushed into a chain
// of 513 sorting cells. A cell keeps the smaller entry and hands the larger
// one to its neighbour, so once the frame is in and the chain has drained,
// cell c holds the entry of rank c. The chain is then shifted out towards
// cell 0, one rank per cycle, and each rank's mirror position is compared
// with the swap limit to write the bin's flag into the finished bank.
// ----------------------------------------------------------------------------
module spectral_bin_morph_by_rank (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic signed [sbmr_pkg::SAMPLE_BITS-1:0] i_re_one,
    input  wire logic signed [sbmr_pkg::SAMPLE_BITS-1:0] i_im_one,
    input  wire logic signed [sbmr_pkg::SAMPLE_BITS-1:0] i_re_two,
    input  wire logic signed [sbmr_pkg::SAMPLE_BITS-1:0] i_im_two,
    input  wire logic [9:0]                         i_swap_upto,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [sbmr_pkg::SAMPLE_BITS-1:0] o_out_re,
    output logic signed [sbmr_pkg::SAMPLE_BITS-1:0] o_out_im,
    output logic [9:0]                              o_out_bin,
    output logic                                    o_out_last
);
    localparam int S  = sbmr_pkg::SAMPLE_BITS;
    localparam int BW = sbmr_pkg::BIN_W;
    localparam int NB = sbmr_pkg::BINS;

    typedef enum logic [2:0] {
        S_IDLE, S_SQ, S_SUM, S_SQRT, S_OUT, S_DRAIN, S_SHIFT
    } t_state;

    t_state             r_state;
    logic [BW-1:0]      r_k;
    logic [BW-1:0]      r_cnt;
    logic [BW-1:0]      r_limit;
    logic               r_bank;
    logic               r_primed;
    logic [S-1:0]       r_a1, r_b1, r_a2, r_b2;
    logic [2*S-1:0]     r_p1, r_p2, r_p3, r_p4;
    sbmr_pkg::t_entry   r_ins;
    logic               r_o_valid;
    logic [S-1:0]       r_o_re, r_o_im;
    logic [BW-1:0]      r_o_bin;
    logic               r_o_last;

    // Spectrum banks: {re one, im one, re two, im two} per bin.
    logic [4*S-1:0]     r_spec [2][NB];
    logic [4*S-1:0]     r_rd_spec;
    logic               r_flag [2][NB];
    logic               r_rd_flag;

    logic               w_acc;
    logic               w_edge;
    logic [S-1:0]       w_im1, w_im2;
    logic [2*S-1:0]     w_n1, w_n2;
    logic               w_start;
    logic               w_done1, w_done2;
    logic [S-1:0]       w_m1, w_m2, w_diff;
    logic               w_shift;
    logic [BW-1:0]      w_pos;
    logic               w_flag_val;

    sbmr_pkg::t_entry   w_pass [NB];
    sbmr_pkg::t_entry   w_held [NB+1];

    assign w_acc   = i_valid && (r_state == S_IDLE);
    assign o_stall = (r_state != S_IDLE);
    assign w_edge  = (r_k == '0) || (r_k == BW'(sbmr_pkg::HALF_SIZE));
    assign w_im1   = w_edge ? '0 : i_im_one;
    assign w_im2   = w_edge ? '0 : i_im_two;
    assign w_n1    = r_p1 + r_p2;
    assign w_n2    = r_p3 + r_p4;
    assign w_start = (r_state == S_SUM);
    assign w_diff  = (w_m1 > w_m2) ? (w_m1 - w_m2) : (w_m2 - w_m1);
    assign w_shift = (r_state == S_SHIFT);

    // Even ranks fill the mirror order from the front, odd ranks from the back.
    assign w_pos      = r_cnt[0] ? (BW'(sbmr_pkg::HALF_SIZE) - {1'b0, r_cnt[BW-1:1]})
                                 : {1'b0, r_cnt[BW-1:1]};
    assign w_flag_val = (w_pos <= r_limit);

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_spec[r_bank][r_k] <= {i_re_one, w_im1, i_re_two, w_im2};
            r_rd_spec           <= r_spec[~r_bank][r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_flag[r_bank][w_held[0].bin] <= w_flag_val;
        end
        if (w_acc) begin
            r_rd_flag <= r_flag[~r_bank][r_k];
        end
    end

    sbmr_isqrt u_mag_one (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_n     (w_n1),
        .o_done  (w_done1),
        .o_root  (w_m1)
    );

    sbmr_isqrt u_mag_two (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_n     (w_n2),
        .o_done  (w_done2),
        .o_root  (w_m2)
    );

    assign w_pass[0]  = r_ins;
    assign w_held[NB] = '0;

    for (genvar c = 0; c < NB; c++) begin : g_cell
        if (c < NB - 1) begin : g_mid
            sbmr_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_in    (w_pass[c]),
                .i_next  (w_held[c+1]),
                .o_pass  (w_pass[c+1]),
                .o_held  (w_held[c])
            );
        end else begin : g_end
            // The last cell never overflows: a frame has exactly as many bins as cells.
            sbmr_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (w_shift),
                .i_in    (w_pass[c]),
                .i_next  (w_held[c+1]),
                .o_pass  (),
                .o_held  (w_held[c])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_k       <= '0;
            r_cnt     <= '0;
            r_limit   <= '0;
            r_bank    <= 1'b0;
            r_primed  <= 1'b0;
            r_ins.vld <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            // The entry valid is a one-cycle strobe, registered from both roots landing.
            r_ins.vld <= (r_state == S_SQRT) && w_done1 && w_done2;
            if (r_o_valid && !i_stall && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        if (r_k == '0) begin
                            r_limit <= (i_swap_upto > BW'(sbmr_pkg::HALF_SIZE))
                                       ? BW'(sbmr_pkg::HALF_SIZE) : i_swap_upto;
                        end
                        r_a1    <= sbmr_pkg::abs_val(i_re_one);
                        r_b1    <= sbmr_pkg::abs_val(w_im1);
                        r_a2    <= sbmr_pkg::abs_val(i_re_two);
                        r_b2    <= sbmr_pkg::abs_val(w_im2);
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_p1    <= (2*S)'(r_a1) * (2*S)'(r_a1);
                    r_p2    <= (2*S)'(r_b1) * (2*S)'(r_b1);
                    r_p3    <= (2*S)'(r_a2) * (2*S)'(r_a2);
                    r_p4    <= (2*S)'(r_b2) * (2*S)'(r_b2);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_state <= S_SQRT;
                end
                S_SQRT: begin
                    if (w_done1 && w_done2) begin
                        r_ins.diff <= w_diff;
                        r_ins.bin  <= r_k;
                        r_state    <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid <= 1'b1;
                        r_o_bin   <= r_k;
                        r_o_last  <= (r_k == BW'(sbmr_pkg::HALF_SIZE));
                        if (!r_primed) begin
                            r_o_re <= '0;
                            r_o_im <= '0;
                        end else if (r_rd_flag) begin
                            r_o_re <= r_rd_spec[2*S-1:S];
                            r_o_im <= r_rd_spec[S-1:0];
                        end else begin
                            r_o_re <= r_rd_spec[4*S-1:3*S];
                            r_o_im <= r_rd_spec[3*S-1:2*S];
                        end
                        if (r_k == BW'(sbmr_pkg::HALF_SIZE)) begin
                            r_cnt   <= '0;
                            r_state <= S_DRAIN;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_DRAIN: begin
                    // Give the last entry time to travel the full chain.
                    if (r_cnt == BW'(sbmr_pkg::HALF_SIZE)) begin
                        r_cnt   <= '0;
                        r_state <= S_SHIFT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_SHIFT: begin
                    if (r_cnt == BW'(sbmr_pkg::HALF_SIZE)) begin
                        r_cnt    <= '0;
                        r_k      <= '0;
                        r_bank   <= ~r_bank;
                        r_primed <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid    = r_o_valid;
    assign o_out_re   = r_o_re;
    assign o_out_im   = r_o_im;
    assign o_out_bin  = r_o_bin;
    assign o_out_last = r_o_last;
endmodule
`default_nettype wire
